[sv/half_open_interval_set_core_assert.svh]
// Assertion macros for the interval set RTL.
`ifndef HALF_OPEN_INTERVAL_SET_CORE_ASSERT_SVH
`define HALF_OPEN_INTERVAL_SET_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HOIS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HOIS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hois_pkg.sv]
// Types and codes for the half-open interval set.
package hois_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam int FIELD_BITS = 32;
    localparam int USE_BITS   = 7;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [FIELD_BITS-1:0] range_left;
        logic [FIELD_BITS-1:0] range_right;
    } req_t;

    typedef struct packed {
        logic                covered;
        logic                table_full;
        logic [USE_BITS-1:0] entries_in_use;
    } rsp_t;

endpackage

[sv/half_open_interval_set_core.sv]
// Top level of the half-open interval set: sequencer over a double-banked bound table.
//
// Usage: drive req and raise start; the request is taken at a clock edge where
// start is high and busy is low. Exactly one result per request appears on rsp
// with done high for a single cycle; the receiver cannot stall it, so the
// result must be captured in that cycle.
// Opcodes: add, remove, query and a no-op code. Empty ranges, the no-op code
// and a remove on an empty table finish at once: done rises the cycle after
// acceptance and busy never rises.
// Other requests walk the stored entries once through the table RAM, with a
// read step and then an evaluate step per entry, plus an extra step when an
// entry splits or the merged range goes in ahead of an entry, and finish
// through the flush and done states; the next request is taken in the done
// cycle. The single registered read port of the RAM sets this order of steps.
// Add and remove stream the new table into the idle bank and flip banks only
// when the result fits; otherwise the old bank stays live and table_full is 1.
// Reset clears the entry count and bank select; the RAM needs no clearing
// since only entries below the count are read.
module half_open_interval_set_core #(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_BITS    = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hois_pkg::req_t req,
    output logic          done,
    output hois_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int K_W   = $clog2(MAX_INTERVALS + 2);
    localparam int AW    = IDX_W + 1;
    localparam int DW    = 2 * COORD_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_EX    = 3'd2;
    localparam logic [2:0] ST_EX2   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_MERGE  = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;

    logic [2:0]            state_reg, state_next;
    logic                  bank_reg, bank_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [1:0]            op_reg, op_next;
    logic [COORD_BITS-1:0] a_reg, a_next;
    logic [COORD_BITS-1:0] b_reg, b_next;
    logic [COORD_BITS-1:0] lo_acc_reg, lo_acc_next;
    logic [COORD_BITS-1:0] hi_acc_reg, hi_acc_next;
    logic [COORD_BITS-1:0] pend_lo_reg, pend_lo_next;
    logic [COORD_BITS-1:0] pend_hi_reg, pend_hi_next;
    logic [1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic                  hit_reg, hit_next;
    logic                  done_reg, done_next;
    hois_pkg::rsp_t        rsp_reg, rsp_next;

    logic                  accept;
    logic                  quick;
    logic [COORD_BITS-1:0] in_a;
    logic [COORD_BITS-1:0] in_b;
    logic                  emit;
    logic [COORD_BITS-1:0] emit_lo;
    logic [COORD_BITS-1:0] emit_hi;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic [COORD_BITS-1:0] rd_lo;
    logic [COORD_BITS-1:0] rd_hi;
    logic                  overflow;

    assign in_a   = COORD_BITS'(req.range_left);
    assign in_b   = COORD_BITS'(req.range_right);
    assign accept = start && !busy;
    assign quick  = (req.opcode == hois_pkg::OP_NOP) || (in_a >= in_b)
                    || ((req.opcode == hois_pkg::OP_REMOVE) && (count_reg == '0));

    assign rd_lo   = rd_data[DW-1:COORD_BITS];
    assign rd_hi   = rd_data[COORD_BITS-1:0];
    assign rd_addr = {bank_reg, idx_reg[IDX_W-1:0]};
    // New table goes to the idle bank; slots past the end are counted, not written.
    assign wr_addr = {~bank_reg, k_reg[IDX_W-1:0]};
    assign wr_en   = emit && (k_reg < K_W'(MAX_INTERVALS));
    assign overflow = k_reg > K_W'(MAX_INTERVALS);

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    hois_ram #(
        .WIDTH (DW),
        .DEPTH (2 << IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({emit_lo, emit_hi}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        bank_next    = bank_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        lo_acc_next  = lo_acc_reg;
        hi_acc_next  = hi_acc_reg;
        pend_lo_next = pend_lo_reg;
        pend_hi_next = pend_hi_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        hit_next     = hit_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        emit         = 1'b0;
        emit_lo      = rd_lo;
        emit_hi      = rd_hi;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.opcode;
                    a_next      = in_a;
                    b_next      = in_b;
                    lo_acc_next = in_a;
                    hi_acc_next = in_b;
                    phase_next  = PH_BEFORE;
                    idx_next    = '0;
                    k_next      = '0;
                    hit_next    = 1'b0;
                    if (quick)
                    begin
                        done_next               = 1'b1;
                        rsp_next.covered        = (req.opcode == hois_pkg::OP_QUERY);
                        rsp_next.table_full     = 1'b0;
                        rsp_next.entries_in_use = hois_pkg::USE_BITS'(count_reg);
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_EX;
                end
            end
            ST_EX:
            begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_RD;
                case (op_reg)
                    hois_pkg::OP_ADD:
                    begin
                        if ((phase_reg == PH_BEFORE) && (rd_hi < a_reg))
                        begin
                            emit = 1'b1;
                        end
                        else if (phase_reg != PH_AFTER)
                        begin
                            if (rd_lo <= hi_acc_reg)
                            begin
                                // absorb the entry into the growing range
                                phase_next = PH_MERGE;
                                if (rd_lo < lo_acc_reg)
                                begin
                                    lo_acc_next = rd_lo;
                                end
                                if (rd_hi > hi_acc_reg)
                                begin
                                    hi_acc_next = rd_hi;
                                end
                            end
                            else
                            begin
                                // insert the merged range, hold this entry for the next slot
                                emit         = 1'b1;
                                emit_lo      = lo_acc_reg;
                                emit_hi      = hi_acc_reg;
                                pend_lo_next = rd_lo;
                                pend_hi_next = rd_hi;
                                phase_next   = PH_AFTER;
                                state_next   = ST_EX2;
                            end
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    hois_pkg::OP_REMOVE:
                    begin
                        if ((rd_hi <= a_reg) || (rd_lo >= b_reg))
                        begin
                            emit = 1'b1;
                        end
                        else if (rd_lo < a_reg)
                        begin
                            emit    = 1'b1;
                            emit_hi = a_reg;
                            if (rd_hi > b_reg)
                            begin
                                // split: right piece goes out next cycle
                                pend_lo_next = b_reg;
                                pend_hi_next = rd_hi;
                                state_next   = ST_EX2;
                            end
                        end
                        else if (rd_hi > b_reg)
                        begin
                            emit    = 1'b1;
                            emit_lo = b_reg;
                        end
                    end
                    hois_pkg::OP_QUERY:
                    begin
                        if ((rd_lo <= a_reg) && (rd_hi >= b_reg))
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EX2:
            begin
                emit       = 1'b1;
                emit_lo    = pend_lo_reg;
                emit_hi    = pend_hi_reg;
                state_next = ST_RD;
            end
            ST_FLUSH:
            begin
                if ((op_reg == hois_pkg::OP_ADD) && (phase_reg != PH_AFTER))
                begin
                    emit    = 1'b1;
                    emit_lo = lo_acc_reg;
                    emit_hi = hi_acc_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next          = ST_IDLE;
                done_next           = 1'b1;
                rsp_next.covered    = (op_reg == hois_pkg::OP_QUERY) && hit_reg;
                rsp_next.table_full = 1'b0;
                rsp_next.entries_in_use = hois_pkg::USE_BITS'(count_reg);
                if ((op_reg == hois_pkg::OP_ADD) || (op_reg == hois_pkg::OP_REMOVE))
                begin
                    if (overflow)
                    begin
                        rsp_next.table_full = 1'b1;
                    end
                    else
                    begin
                        bank_next  = ~bank_reg;
                        count_next = CNT_W'(k_reg);
                        rsp_next.entries_in_use = hois_pkg::USE_BITS'(k_reg);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            k_next = k_reg + K_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        lo_acc_reg  <= lo_acc_next;
        hi_acc_reg  <= hi_acc_next;
        pend_lo_reg <= pend_lo_next;
        pend_hi_reg <= pend_hi_next;
        phase_reg   <= phase_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        hit_reg     <= hit_next;
        rsp_reg     <= rsp_next;
    end

`include "half_open_interval_set_core_assert.svh"

    `HOIS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_INTERVALS), "entry count exceeds table size")
    `HOIS_ASSERT_IMP(a_write_idle_bank, clk, rst_n, wr_en, wr_addr[AW-1] != bank_reg, "write hits the live bank")
    `HOIS_ASSERT_IMP(a_full_keeps_count, clk, rst_n, done_reg && rsp_reg.table_full, count_reg == $past(count_reg), "refused request changed the count")
    `HOIS_ASSERT_NXT(a_done_source, clk, rst_n, (state_reg == ST_DONE) || (accept && quick), done_reg, "result strobe missing")

endmodule

[sv/hois_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hois_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[test/hois_checker.sv]
`timescale 1ns / 1ps
// Result checker for the interval set: mirrors the range table and compares every response.
module hois_checker #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  hois_pkg::req_t req,
    input  logic           done,
    input  hois_pkg::rsp_t rsp,
    output int             mismatch_count,
    output int             pending_count
);

    typedef logic [hois_pkg::FIELD_BITS-1:0] coord_t;

    coord_t         span_lo [MAX_INTERVALS];
    coord_t         span_hi [MAX_INTERVALS];
    int             span_count = 0;
    coord_t         next_lo [MAX_INTERVALS+2];
    coord_t         next_hi [MAX_INTERVALS+2];
    hois_pkg::rsp_t expected_rsp [$];
    int             errors = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        errors++;
    endtask

    // Keep the old table when the rebuilt one does not fit.
    function automatic bit commit_spans(input int n);
        int j;
        if (n > MAX_INTERVALS)
        begin
            return 1'b0;
        end
        for (j = 0; j < n; j++)
        begin
            span_lo[j] = next_lo[j];
            span_hi[j] = next_hi[j];
        end
        span_count = n;
        return 1'b1;
    endfunction

    function automatic hois_pkg::rsp_t predict_interval_op(input hois_pkg::req_t r);
        hois_pkg::rsp_t res;
        coord_t         a;
        coord_t         b;
        coord_t         lo;
        coord_t         hi;
        int             i;
        int             k;
        bit             fits;
        a    = r.range_left;
        b    = r.range_right;
        res  = '0;
        fits = 1'b1;
        k    = 0;
        case (r.opcode)
            hois_pkg::OP_ADD:
            begin
                if (a < b)
                begin
                    i  = 0;
                    lo = a;
                    hi = b;
                    while (i < span_count && span_hi[i] < a)
                    begin
                        next_lo[k] = span_lo[i];
                        next_hi[k] = span_hi[i];
                        k++;
                        i++;
                    end
                    // absorb every entry that overlaps or touches the growing range
                    while (i < span_count && span_lo[i] <= hi)
                    begin
                        if (span_lo[i] < lo)
                            lo = span_lo[i];
                        if (span_hi[i] > hi)
                            hi = span_hi[i];
                        i++;
                    end
                    next_lo[k] = lo;
                    next_hi[k] = hi;
                    k++;
                    while (i < span_count)
                    begin
                        next_lo[k] = span_lo[i];
                        next_hi[k] = span_hi[i];
                        k++;
                        i++;
                    end
                    fits = commit_spans(k);
                end
            end
            hois_pkg::OP_REMOVE:
            begin
                if (a < b && span_count != 0)
                begin
                    for (i = 0; i < span_count; i++)
                    begin
                        if (span_hi[i] <= a || span_lo[i] >= b)
                        begin
                            next_lo[k] = span_lo[i];
                            next_hi[k] = span_hi[i];
                            k++;
                        end
                        else
                        begin
                            if (span_lo[i] < a)
                            begin
                                next_lo[k] = span_lo[i];
                                next_hi[k] = a;
                                k++;
                            end
                            if (span_hi[i] > b)
                            begin
                                next_lo[k] = b;
                                next_hi[k] = span_hi[i];
                                k++;
                            end
                        end
                    end
                    fits = commit_spans(k);
                end
            end
            hois_pkg::OP_QUERY:
            begin
                res.covered = (a >= b);
                for (i = 0; i < span_count; i++)
                begin
                    if (span_lo[i] <= a && span_hi[i] >= b)
                        res.covered = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.table_full     = !fits;
        res.entries_in_use = hois_pkg::USE_BITS'(span_count);
        return res;
    endfunction

    always @(posedge clk)
    begin : watch_channels
        hois_pkg::rsp_t oldest;
        if (!rst_n)
        begin
            span_count = 0;
            expected_rsp.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    report_mismatch("response with no request pending");
                end
                else
                begin
                    oldest = expected_rsp.pop_front();
                    if (rsp.covered !== oldest.covered)
                        report_mismatch($sformatf("covered got %b expected %b",
                                                  rsp.covered, oldest.covered));
                    if (rsp.table_full !== oldest.table_full)
                        report_mismatch($sformatf("table_full got %b expected %b",
                                                  rsp.table_full, oldest.table_full));
                    if (rsp.entries_in_use !== oldest.entries_in_use)
                        report_mismatch($sformatf("entries_in_use got %0d expected %0d",
                                                  rsp.entries_in_use,
                                                  oldest.entries_in_use));
                end
            end
            if (start && !busy)
                expected_rsp.push_back(predict_interval_op(req));
        end
        mismatch_count <= errors;
        pending_count  <= expected_rsp.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Top of the interval set testbench: clock, reset, request stimulus and verdict.
module tb_top;

    localparam int MAX_INTERVALS = 64;
    localparam int ITEM_TARGET   = 1050;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 200;
    localparam logic [hois_pkg::FIELD_BITS-1:0] COORD_TOP = '1;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    hois_pkg::req_t req   = '0;
    logic           busy;
    logic           done;
    hois_pkg::rsp_t rsp;

    int mismatch_count;
    int pending_count;
    int idle_cycles = 0;
    int op_count    = 0;
    int burst_left  = 1;

    logic [hois_pkg::FIELD_BITS-1:0] grid_base = '0;

    always #2 clk = ~clk;

    half_open_interval_set_core #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .COORD_BITS   (hois_pkg::FIELD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    hois_checker #(
        .MAX_INTERVALS(MAX_INTERVALS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .rsp           (rsp),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Hold the request until busy is low at a rising edge, then idle between bursts.
    task automatic issue_request(input logic [1:0] op,
                                 input logic [hois_pkg::FIELD_BITS-1:0] lft,
                                 input logic [hois_pkg::FIELD_BITS-1:0] rgt);
        int gap;
        start <= 1'b1;
        req   <= '{opcode: op, range_left: lft, range_right: rgt};
        do
            @(posedge clk);
        while (busy);
        op_count++;
        burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160)
                                              : $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Slots are 16 apart, so short ranges in distinct slots never touch.
    function automatic logic [hois_pkg::FIELD_BITS-1:0] grid_point(input int slot,
                                                                   input int off);
        return grid_base + hois_pkg::FIELD_BITS'(slot * 16 + off);
    endfunction

    function automatic logic [hois_pkg::FIELD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return COORD_TOP;
            2:       return grid_point($urandom_range(0, 127), $urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        logic [hois_pkg::FIELD_BITS-1:0] lft;
        logic [hois_pkg::FIELD_BITS-1:0] rgt;
        logic [1:0]                      op;
        int                              pick;
        int                              slot;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: whole space, empty ranges, split, trims, merges, no-op
        issue_request(hois_pkg::OP_ADD,    '0, COORD_TOP);
        issue_request(hois_pkg::OP_QUERY,  '0, COORD_TOP);
        issue_request(hois_pkg::OP_QUERY,  32'd5, 32'd5);
        issue_request(hois_pkg::OP_QUERY,  COORD_TOP, '0);
        issue_request(hois_pkg::OP_REMOVE, 32'd10, 32'd20);
        issue_request(hois_pkg::OP_QUERY,  32'd10, 32'd20);
        issue_request(hois_pkg::OP_QUERY,  '0, 32'd10);
        issue_request(hois_pkg::OP_QUERY,  32'd9, 32'd21);
        issue_request(hois_pkg::OP_REMOVE, '0, COORD_TOP);
        issue_request(hois_pkg::OP_REMOVE, 32'd1, 32'd5);
        issue_request(hois_pkg::OP_ADD,    32'd7, 32'd3);
        issue_request(hois_pkg::OP_NOP,    COORD_TOP, COORD_TOP);
        issue_request(hois_pkg::OP_ADD,    32'd100, 32'd200);
        issue_request(hois_pkg::OP_ADD,    32'd200, 32'd300);
        issue_request(hois_pkg::OP_ADD,    32'd50, 32'd100);
        issue_request(hois_pkg::OP_ADD,    32'd400, 32'd500);
        issue_request(hois_pkg::OP_QUERY,  32'd250, 32'd450);
        issue_request(hois_pkg::OP_ADD,    32'd250, 32'd450);
        issue_request(hois_pkg::OP_REMOVE, 32'd600, 32'd700);
        issue_request(hois_pkg::OP_REMOVE, 32'd40, 32'd60);
        issue_request(hois_pkg::OP_REMOVE, 32'd450, COORD_TOP);
        issue_request(hois_pkg::OP_REMOVE, 32'd300, 32'd200);
        issue_request(hois_pkg::OP_ADD,    COORD_TOP - 1, COORD_TOP);
        issue_request(hois_pkg::OP_QUERY,  COORD_TOP - 1, COORD_TOP);

        // random: mostly grid traffic that fills, splits and overflows the table
        while (op_count < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0, 1:    grid_base = '0;
                2:       grid_base = {16'($urandom_range(1, 16'hFFFE)), 16'h0};
                default: grid_base = COORD_TOP - 32'hFFF;
            endcase
            pick = $urandom_range(0, 19);
            case (pick)
                0, 1, 2, 3, 4, 5:
                begin
                    repeat ($urandom_range(8, 40))
                    begin
                        lft = grid_point($urandom_range(0, 127), $urandom_range(0, 8));
                        issue_request(hois_pkg::OP_ADD, lft, lft + $urandom_range(1, 6));
                    end
                end
                6, 7, 8:
                begin
                    repeat ($urandom_range(2, 12))
                    begin
                        lft = grid_point($urandom_range(0, 127), $urandom_range(0, 12));
                        issue_request(hois_pkg::OP_REMOVE, lft, lft + $urandom_range(1, 5));
                    end
                end
                9, 10, 11, 12:
                begin
                    repeat ($urandom_range(4, 16))
                    begin
                        lft = grid_point($urandom_range(0, 127), $urandom_range(0, 10));
                        issue_request(hois_pkg::OP_QUERY, lft, lft + $urandom_range(0, 6));
                    end
                end
                13, 14:
                begin
                    slot = $urandom_range(0, 100);
                    lft  = grid_point(slot, $urandom_range(0, 15));
                    op   = ($urandom_range(0, 2) == 0) ? hois_pkg::OP_REMOVE
                                                       : hois_pkg::OP_ADD;
                    issue_request(op, lft, lft + $urandom_range(16, 300));
                end
                15:
                begin
                    issue_request(hois_pkg::OP_REMOVE, '0, COORD_TOP);
                end
                16, 17:
                begin
                    repeat ($urandom_range(1, 4))
                        issue_request(2'($urandom_range(0, 2)), rand_coord(), rand_coord());
                end
                default:
                begin
                    // noise: any opcode, wild bounds, often empty
                    repeat ($urandom_range(1, 6))
                    begin
                        lft = $urandom;
                        rgt = ($urandom_range(0, 2) == 0) ? lft : $urandom;
                        issue_request(2'($urandom_range(0, 3)), lft, rgt);
                    end
                end
            endcase
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/hois_pkg.sv
sv/hois_ram.sv
sv/half_open_interval_set_core.sv
test/hois_checker.sv
test/tb_top.sv
